### rtl/core/imu_angle_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_assert.svh
// Assertion macros shared by the angle frame parser RTL.
// ----------------------------------------------------------------------------
`ifndef IMU_ANGLE_FRAME_PARSER_ASSERT_SVH
`define IMU_ANGLE_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IMUAFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IMUAFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/imuafp_pkg.sv
// ----------------------------------------------------------------------------
// imuafp_pkg
// Frame constants and scaling functions for the IMU angle frame parser.
// ----------------------------------------------------------------------------
package imuafp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] ANGLE_TYPE = 8'h53;

  // Frame positions: bytes 0..9 are stored and summed, byte 10 is the checksum.
  localparam int unsigned STORE_LEN = 10;
  localparam logic [3:0]  TEMP_HI_POS = 4'd9;
  localparam logic [3:0]  FINAL_POS   = 4'd10;

  // floor(n/17) for n = raw*5 is taken as floor((n + 17*BIAS_Q)/17) - BIAS_Q,
  // which keeps the dividend positive. The quotient estimate uses a
  // truncated reciprocal of 2^24/17 and is low by at most one.
  localparam int unsigned    TEMP_M_W  = 19;
  localparam int unsigned    TEMP_Q_W  = 15;
  localparam int unsigned    RECIP_W   = 20;
  localparam int unsigned    RECIP_SH  = 24;
  localparam logic [RECIP_W-1:0] RECIP_17 = 20'd986895;
  localparam logic signed [20:0] TEMP_BIAS = 21'sd170000;
  localparam logic [TEMP_M_W-1:0] DIV_17 = 19'd17;
  // -BIAS_Q + 3625 offset of the sensor scale
  localparam logic signed [15:0] TEMP_ADJ = 16'sd6375;

  typedef logic [TEMP_M_W-1:0] temp_m_t;
  typedef logic [TEMP_Q_W-1:0] temp_q_t;

  // raw * 180 / 256, floored (arithmetic shift)
  function automatic logic signed [15:0] angle_scale(input logic signed [15:0] raw);
    logic signed [23:0] p;
    p = 24'(raw) * 24'sd180;
    return p[23:8];
  endfunction

  // biased dividend raw*5 + 17*BIAS_Q, always positive and below 2^19
  function automatic temp_m_t temp_dividend(input logic signed [15:0] raw);
    logic signed [20:0] s;
    s = 21'(raw) * 21'sd5 + TEMP_BIAS;
    return s[TEMP_M_W-1:0];
  endfunction

  // quotient estimate from the reciprocal product
  function automatic temp_q_t temp_estimate(input temp_m_t m);
    logic [TEMP_M_W+RECIP_W-1:0] p;
    p = (TEMP_M_W+RECIP_W)'(m) * (TEMP_M_W+RECIP_W)'(RECIP_17);
    return p[RECIP_SH +: TEMP_Q_W];
  endfunction

  // one correction step, then remove the bias and add the sensor offset
  function automatic logic signed [14:0] temp_finish(input temp_m_t m, input temp_q_t q0);
    temp_m_t            prod17;
    temp_m_t            rem;
    temp_q_t            q;
    logic signed [15:0] t;
    prod17 = {q0, 4'b0000} + TEMP_M_W'(q0);
    rem    = m - prod17;
    q      = (rem >= DIV_17) ? q0 + 1'b1 : q0;
    t      = $signed({1'b0, q}) - TEMP_ADJ;
    return t[14:0];
  endfunction

endpackage

### rtl/core/imu_angle_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_angle_frame_parser
// Byte-serial parser for the 11-byte angle frame of a serial IMU.
//
// Feed one received byte per beat on rx_byte. Bytes seen while waiting for
// a frame start are dropped until the header 0x55 arrives; then ten bytes
// are kept with an 8-bit running sum and the eleventh is checked against it.
// An angle frame (type 0x53) yields one result beat: status 0 with the three
// angles in 1/128 degree and the temperature in 1/100 degree C, or status 1
// with zero fields on a checksum mismatch. Other frame types yield nothing.
// A byte may be offered on every cycle; the result register sits between
// the two sides, so only the checksum byte is held back while a previous
// result is still stalled. The temperature division by 17 is split across
// the last two bytes: the reciprocal multiply runs when the temperature
// high byte arrives, the correction step runs with the checksum byte. The
// result is registered and appears in the cycle after the checksum byte is
// accepted.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic signed [15:0] angle_x,
  output logic signed [15:0] angle_y,
  output logic signed [15:0] angle_z,
  output logic signed [14:0] temperature
);
  import imuafp_pkg::*;

  // frame tracking
  logic [3:0] byte_index, byte_index_next;
  logic [7:0] running_sum, running_sum_next;
  logic       out_valid_next;
  logic [7:0] frame_store [STORE_LEN];

  // temperature division, first half
  temp_m_t temp_m;
  temp_q_t temp_q0;

  logic in_accept;
  logic is_final;
  logic hdr_drop;
  logic out_take;
  logic frame_done;
  logic sum_ok;

  // Index is never above the final position; anything at or beyond it is
  // treated as the checksum byte.
  assign is_final   = (byte_index >= FINAL_POS);
  assign out_take   = out_valid && !out_stall;
  // Only the checksum byte needs the result register.
  assign in_stall   = out_valid && out_stall && is_final;
  assign in_accept  = in_valid && !in_stall;
  assign hdr_drop   = (byte_index == '0) && (rx_byte != HDR_BYTE);
  assign frame_done = in_accept && is_final;
  assign sum_ok     = (rx_byte == running_sum);

  always_comb begin
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    out_valid_next   = out_valid && !out_take;
    if (in_accept && !hdr_drop) begin
      if (is_final) begin
        byte_index_next  = '0;
        running_sum_next = '0;
        if (frame_store[1] == ANGLE_TYPE) begin
          out_valid_next = 1'b1;
        end
      end else begin
        byte_index_next  = byte_index + 4'd1;
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      out_valid   <= out_valid_next;
    end
  end

  // Byte store and temperature pre-scale; payload, no reset.
  always_ff @(posedge clk) begin
    if (in_accept && !hdr_drop && !is_final) begin
      frame_store[byte_index[3:0]] <= rx_byte;
      if (byte_index == TEMP_HI_POS) begin
        temp_m  <= temp_dividend($signed({rx_byte, frame_store[8]}));
        temp_q0 <= temp_estimate(temp_dividend($signed({rx_byte, frame_store[8]})));
      end
    end
  end

  // Result register; loaded on the checksum byte of an angle frame.
  always_ff @(posedge clk) begin
    if (frame_done && (frame_store[1] == ANGLE_TYPE)) begin
      if (sum_ok) begin
        status      <= 1'b0;
        angle_x     <= angle_scale($signed({frame_store[3], frame_store[2]}));
        angle_y     <= angle_scale($signed({frame_store[5], frame_store[4]}));
        angle_z     <= angle_scale($signed({frame_store[7], frame_store[6]}));
        temperature <= temp_finish(temp_m, temp_q0);
      end else begin
        status      <= 1'b1;
        angle_x     <= '0;
        angle_y     <= '0;
        angle_z     <= '0;
        temperature <= '0;
      end
    end
  end

`include "imu_angle_frame_parser_assert.svh"

  `IMUAFP_ASSERT_NOW(a_index_range, 1'b1, byte_index <= FINAL_POS, "frame index past final byte")
  `IMUAFP_ASSERT_NOW(a_result_source, $rose(out_valid), $past(frame_done), "result without a checksum byte")
  `IMUAFP_ASSERT_NEXT(a_hdr_drop, in_accept && hdr_drop, byte_index == '0 && running_sum == '0, "dropped byte changed state")
  `IMUAFP_ASSERT_NEXT(a_frame_restart, frame_done, byte_index == '0 && running_sum == '0, "frame did not restart")

endmodule
